FILE: src/tagged_value_alu_defines.svh
// assertion macros for the tagged value alu
`ifndef TAGGED_VALUE_ALU_DEFINES_SVH
`define TAGGED_VALUE_ALU_DEFINES_SVH

// condition pre implies condition post in the same cycle
`define TVA_ASSERT_IMPLIES(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("tagged value alu check failed");

// condition never holds
`define TVA_ASSERT_NEVER(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("tagged value alu check failed");

`endif

FILE: src/tva_pkg.sv
// shared types and codes of the tagged value alu
package tva_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int FIFO_DEPTH_DEF = 4;

    typedef enum logic [3:0] {
        OP_NOT, OP_AND, OP_OR, OP_EQ, OP_NE, OP_GT, OP_LT,
        OP_GE, OP_LE, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD
    } op_t;

    localparam logic [1:0] TAG_INT  = 2'd0;
    localparam logic [1:0] TAG_BOOL = 2'd1;

    localparam logic [1:0] RES_INT  = 2'd0;
    localparam logic [1:0] RES_BOOL = 2'd1;
    localparam logic [1:0] RES_ERR  = 2'd2;

    localparam logic [1:0] ERR_NONE = 2'd0;
    localparam logic [1:0] ERR_TYPE = 2'd1;
    localparam logic [1:0] ERR_DIV0 = 2'd2;
    localparam logic [1:0] ERR_MOD0 = 2'd3;

    typedef enum logic [1:0] {KIND_SIMPLE, KIND_MUL, KIND_DIV, KIND_MOD} kind_t;

    typedef struct packed {
        kind_t      kind;
        logic       neg;
        logic [1:0] tag;
        logic [1:0] err;
    } ctrl_t;

    localparam int CTRL_W = $bits(ctrl_t);

endpackage

FILE: src/tva_front.sv
// front end: accepts items, checks tags, settles simple ops, prepares operands
module tva_front #(
    parameter int W = tva_pkg::DATA_WIDTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [3:0]          op,
    input  logic [1:0]          left_tag,
    input  logic signed [W-1:0] left_value,
    input  logic [1:0]          right_tag,
    input  logic signed [W-1:0] right_value,
    output logic                push_valid,
    input  logic                push_full,
    output tva_pkg::ctrl_t      push_ctrl,
    output logic [W-1:0]        push_a,
    output logic [W-1:0]        push_b
);
    import tva_pkg::*;

    logic         valid_reg;
    ctrl_t        ctrl_reg, ctrl_next;
    logic [W-1:0] a_reg, a_next;
    logic [W-1:0] b_reg, b_next;
    logic         advance;
    logic         both_bool, both_int, lnz, rnz, na, nb;
    logic [W-1:0] ma, mb;

    assign advance  = !valid_reg || !push_full;
    assign in_stall = valid_reg && push_full;

    assign both_bool = (left_tag == TAG_BOOL) && (right_tag == TAG_BOOL);
    assign both_int  = (left_tag == TAG_INT) && (right_tag == TAG_INT);
    assign lnz = |left_value;
    assign rnz = |right_value;
    assign na  = left_value[W-1];
    assign nb  = right_value[W-1];
    assign ma  = na ? (~left_value + 1'b1) : left_value;
    assign mb  = nb ? (~right_value + 1'b1) : right_value;

    always_comb
    begin
        ctrl_next.kind = KIND_SIMPLE;
        ctrl_next.neg  = 1'b0;
        ctrl_next.tag  = RES_ERR;
        ctrl_next.err  = ERR_TYPE;
        a_next = '0;
        b_next = '0;
        case (op_t'(op))
            OP_NOT:
            begin
                if (left_tag == TAG_BOOL)
                begin
                    ctrl_next.tag = RES_BOOL;
                    ctrl_next.err = ERR_NONE;
                    a_next = W'(!lnz);
                end
            end
            OP_AND, OP_OR:
            begin
                if (both_bool)
                begin
                    ctrl_next.tag = RES_BOOL;
                    ctrl_next.err = ERR_NONE;
                    a_next = (op_t'(op) == OP_AND) ? W'(lnz && rnz) : W'(lnz || rnz);
                end
            end
            OP_EQ, OP_NE, OP_GT, OP_LT, OP_GE, OP_LE:
            begin
                if (both_int)
                begin
                    ctrl_next.tag = RES_BOOL;
                    ctrl_next.err = ERR_NONE;
                    case (op_t'(op))
                        OP_EQ:   a_next = W'(left_value == right_value);
                        OP_NE:   a_next = W'(left_value != right_value);
                        OP_GT:   a_next = W'(left_value > right_value);
                        OP_LT:   a_next = W'(left_value < right_value);
                        OP_GE:   a_next = W'(left_value >= right_value);
                        default: a_next = W'(left_value <= right_value);
                    endcase
                end
            end
            OP_ADD, OP_SUB:
            begin
                if (both_int)
                begin
                    ctrl_next.tag = RES_INT;
                    ctrl_next.err = ERR_NONE;
                    a_next = (op_t'(op) == OP_ADD) ? (left_value + right_value)
                                                   : (left_value - right_value);
                end
            end
            OP_MUL:
            begin
                if (both_int)
                begin
                    ctrl_next.kind = KIND_MUL;
                    ctrl_next.tag  = RES_INT;
                    ctrl_next.err  = ERR_NONE;
                    a_next = left_value;
                    b_next = right_value;
                end
            end
            OP_DIV, OP_MOD:
            begin
                if (both_int)
                begin
                    if (!rnz)
                    begin
                        ctrl_next.err = (op_t'(op) == OP_DIV) ? ERR_DIV0 : ERR_MOD0;
                    end
                    else
                    begin
                        ctrl_next.kind = (op_t'(op) == OP_DIV) ? KIND_DIV : KIND_MOD;
                        ctrl_next.neg  = (op_t'(op) == OP_DIV) ? (na ^ nb) : na;
                        ctrl_next.tag  = RES_INT;
                        ctrl_next.err  = ERR_NONE;
                        a_next = ma;
                        b_next = mb;
                    end
                end
            end
            default:
            begin
                ctrl_next.err = ERR_TYPE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid)
        begin
            ctrl_reg <= ctrl_next;
            a_reg    <= a_next;
            b_reg    <= b_next;
        end
    end

    assign push_valid = valid_reg;
    assign push_ctrl  = ctrl_reg;
    assign push_a     = a_reg;
    assign push_b     = b_reg;

endmodule

FILE: src/tva_fifo.sv
// short register queue between front and back end
module tva_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = tva_pkg::FIFO_DEPTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             not_empty,
    output logic [WIDTH-1:0] pop_data
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wptr_reg, rptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push, do_pop;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_data  = mem_reg[rptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wptr_reg <= (wptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rptr_reg <= (rptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wptr_reg] <= push_data;
        end
    end

endmodule

FILE: src/tva_back.sv
// back end: bit-serial pipeline for multiply, divide and modulo, output register
module tva_back #(
    parameter int W = tva_pkg::DATA_WIDTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 pop_valid,
    output logic                 pop_ready,
    input  tva_pkg::ctrl_t       pop_ctrl,
    input  logic [W-1:0]         pop_a,
    input  logic [W-1:0]         pop_b,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [1:0]           result_tag,
    output logic signed [W-1:0]  result_value,
    output logic [1:0]           error_code
);
    import tva_pkg::*;

    logic         v_reg [W+1];
    ctrl_t        c_reg [W+1];
    logic [W-1:0] a_reg [W+1];
    logic [W-1:0] b_reg [W+1];
    logic [W-1:0] r_reg [W+1];

    logic         ov_reg;
    logic [1:0]   otag_reg;
    logic [W-1:0] oval_reg;
    logic [1:0]   oerr_reg;
    logic [W-1:0] fin_next;
    logic         advance;

    assign advance   = !(ov_reg && out_stall);
    assign pop_ready = advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else if (advance)
        begin
            v_reg[0] <= pop_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            c_reg[0] <= pop_ctrl;
            a_reg[0] <= pop_a;
            b_reg[0] <= pop_b;
            r_reg[0] <= '0;
        end
    end

    for (genvar k = 0; k < W; k++)
    begin : g_step
        logic [W:0]   rs, diff;
        logic         ge;
        logic [W-1:0] a_next, b_next, r_next;

        assign rs   = {r_reg[k], a_reg[k][W-1]};
        assign diff = rs - {1'b0, b_reg[k]};
        assign ge   = (rs >= {1'b0, b_reg[k]});

        always_comb
        begin
            a_next = a_reg[k];
            b_next = b_reg[k];
            r_next = r_reg[k];
            case (c_reg[k].kind)
                KIND_MUL:
                begin
                    r_next = r_reg[k] + (b_reg[k][0] ? a_reg[k] : '0);
                    a_next = a_reg[k] << 1;
                    b_next = b_reg[k] >> 1;
                end
                KIND_DIV, KIND_MOD:
                begin
                    a_next = {a_reg[k][W-2:0], ge};
                    r_next = ge ? diff[W-1:0] : rs[W-1:0];
                end
                default:
                begin
                    a_next = a_reg[k];
                end
            endcase
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k+1] <= 1'b0;
            end
            else if (advance)
            begin
                v_reg[k+1] <= v_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                c_reg[k+1] <= c_reg[k];
                a_reg[k+1] <= a_next;
                b_reg[k+1] <= b_next;
                r_reg[k+1] <= r_next;
            end
        end
    end

    always_comb
    begin
        case (c_reg[W].kind)
            KIND_MUL: fin_next = r_reg[W];
            KIND_DIV: fin_next = c_reg[W].neg ? (~a_reg[W] + 1'b1) : a_reg[W];
            KIND_MOD: fin_next = c_reg[W].neg ? (~r_reg[W] + 1'b1) : r_reg[W];
            default:  fin_next = a_reg[W];
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= 1'b0;
        end
        else if (advance)
        begin
            ov_reg <= v_reg[W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            otag_reg <= c_reg[W].tag;
            oval_reg <= fin_next;
            oerr_reg <= c_reg[W].err;
        end
    end

    assign out_valid    = ov_reg;
    assign result_tag   = otag_reg;
    assign result_value = oval_reg;
    assign error_code   = oerr_reg;

endmodule

FILE: src/tagged_value_alu.sv
// top level of the tagged value alu
//
//  channel | direction | handshake          | fields
//  input   | in        | in_valid, in_stall | op, left_tag, left_value, right_tag, right_value
//  result  | out       | out_valid, out_stall | result_tag, result_value, error_code
//
// one item per cycle sustained unless out_stall backs up the flow; items pass the
// front register, queue, one-bit-per-stage multiply/divide pipeline and output register
// asynchronous active-low reset empties front register, queue and pipeline
// a stalled result freezes the back pipeline; the queue of FIFO_DEPTH items (four by
// default) and the front register keep taking items until they fill
`include "tagged_value_alu_defines.svh"

module tagged_value_alu #(
    parameter int DATA_WIDTH = tva_pkg::DATA_WIDTH_DEF,
    parameter int FIFO_DEPTH = tva_pkg::FIFO_DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [3:0]                    op,
    input  logic [1:0]                    left_tag,
    input  logic signed [DATA_WIDTH-1:0]  left_value,
    input  logic [1:0]                    right_tag,
    input  logic signed [DATA_WIDTH-1:0]  right_value,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [1:0]                    result_tag,
    output logic signed [DATA_WIDTH-1:0]  result_value,
    output logic [1:0]                    error_code
);
    import tva_pkg::*;

    localparam int QW = CTRL_W + 2 * DATA_WIDTH;

    logic                  push_valid, fifo_full, pop_ready, fifo_not_empty;
    ctrl_t                 push_ctrl, pop_ctrl;
    logic [DATA_WIDTH-1:0] push_a, push_b, pop_a, pop_b;
    logic [QW-1:0]         push_data, pop_data;

    tva_front #(.W(DATA_WIDTH)) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .op          (op),
        .left_tag    (left_tag),
        .left_value  (left_value),
        .right_tag   (right_tag),
        .right_value (right_value),
        .push_valid  (push_valid),
        .push_full   (fifo_full),
        .push_ctrl   (push_ctrl),
        .push_a      (push_a),
        .push_b      (push_b)
    );

    assign push_data = {push_ctrl, push_a, push_b};

    tva_fifo #(.WIDTH(QW), .DEPTH(FIFO_DEPTH)) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push_valid),
        .push_data (push_data),
        .full      (fifo_full),
        .pop       (pop_ready),
        .not_empty (fifo_not_empty),
        .pop_data  (pop_data)
    );

    assign pop_ctrl = ctrl_t'(pop_data[QW-1 -: CTRL_W]);
    assign pop_a    = pop_data[2*DATA_WIDTH-1 -: DATA_WIDTH];
    assign pop_b    = pop_data[DATA_WIDTH-1:0];

    tva_back #(.W(DATA_WIDTH)) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .pop_valid    (fifo_not_empty),
        .pop_ready    (pop_ready),
        .pop_ctrl     (pop_ctrl),
        .pop_a        (pop_a),
        .pop_b        (pop_b),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .result_tag   (result_tag),
        .result_value (result_value),
        .error_code   (error_code)
    );

    `TVA_ASSERT_IMPLIES(a_err_result, out_valid && result_tag == RES_ERR, result_value == '0 && error_code != ERR_NONE)
    `TVA_ASSERT_IMPLIES(a_ok_result, out_valid && result_tag != RES_ERR, error_code == ERR_NONE)
    `TVA_ASSERT_IMPLIES(a_stall_full, in_stall, fifo_full && push_valid)
    `TVA_ASSERT_NEVER(a_bad_tag, out_valid && result_tag == 2'd3)

endmodule
